// ===== design/cfs_pkg.sv =====
// Types and constants shared by the CSV field splitter modules.
package cfs_pkg;

  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam int unsigned MAX_RESULTS = 3;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
  } cfs_state_t;

endpackage

// ===== design/csv_field_splitter_top.sv =====
// Top level of the CSV field splitter: config register, quote state, result buffer.
//
// One text byte is taken per cycle while the input side is not stalled. A byte that yields
// k results (at most three, and more than one only on the line's final byte) holds the
// input side stalled while the three-entry result register drains one result per cycle
// (while out_stall_i is low); a byte that yields none (an opening or pending quote) does not
// stall the input. The input is taken again in the same cycle as the buffer's final result
// leaves, so ordinary field bytes stream at one per cycle while the receiver does not stall.
module csv_field_splitter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cfs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cfs_pkg::out_item_t out_item_o
);
  import cfs_pkg::*;

  logic [7:0] delim_q;
  cfs_state_t state_q, state_d;
  out_item_t  res_q [MAX_RESULTS];
  out_item_t  res_d [MAX_RESULTS];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic [1:0] dec_count;
  logic       pop;
  logic       accept;
  logic       load;

  cfs_decode u_decode (
    .item_i      (in_item_i),
    .delimiter_i (delim_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_o       (res_d),
    .count_o     (dec_count)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = res_q[idx_q];
  assign pop         = out_valid_o && !out_stall_i;
  // free when empty, or when the final buffered result leaves this cycle
  assign in_stall_o  = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop));
  assign accept      = in_valid_i && !in_stall_o;
  assign load        = accept && (dec_count != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load) begin
      cnt_d = dec_count;
      idx_d = 2'd0;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
      state_q <= '0;
      cnt_q   <= 2'd0;
      idx_q   <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
      if (accept) begin
        state_q <= state_d;
      end
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

endmodule

// ===== design/cfs_decode.sv =====
// Per-byte decode: quote tracking and up to three results for one text byte.
module cfs_decode (
  input  cfs_pkg::in_item_t   item_i,
  input  logic [7:0]          delimiter_i,
  input  cfs_pkg::cfs_state_t state_i,
  output cfs_pkg::cfs_state_t state_o,
  output cfs_pkg::out_item_t  res_o [cfs_pkg::MAX_RESULTS],
  output logic [1:0]          count_o
);
  import cfs_pkg::*;

  always_comb begin
    logic       consumed;
    logic       split;
    logic [1:0] n;
    cfs_state_t st;

    consumed = 1'b0;
    split    = 1'b0;
    n        = 2'd0;
    st       = state_i;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_o[i] = '0;
    end

    if (st.quote_pending) begin
      st.quote_pending = 1'b0;
      if (item_i.text_byte == QUOTE_BYTE) begin
        // doubled quote inside a quoted section
        res_o[n] = '{kind: KIND_DATA, data_byte: QUOTE_BYTE, last: 1'b0};
        n        = n + 2'd1;
        consumed = 1'b1;
      end else begin
        st.in_quotes = 1'b0;
      end
    end

    if (!consumed) begin
      if (!st.in_quotes && item_i.text_byte == delimiter_i) begin
        res_o[n] = '{kind: KIND_EOF, data_byte: 8'd0, last: 1'b0};
        n        = n + 2'd1;
        split    = 1'b1;
      end else if (item_i.text_byte == QUOTE_BYTE) begin
        if (!st.in_quotes) begin
          st.in_quotes = 1'b1;
        end else begin
          st.quote_pending = 1'b1;
        end
      end else begin
        res_o[n] = '{kind: KIND_DATA, data_byte: item_i.text_byte, last: 1'b0};
        n        = n + 2'd1;
      end
    end

    if (item_i.line_end) begin
      if (!split) begin
        res_o[n] = '{kind: KIND_EOF, data_byte: 8'd0, last: 1'b0};
        n        = n + 2'd1;
      end
      // trailing delimiter adds an empty field, even inside open quotes
      if (item_i.text_byte == delimiter_i) begin
        res_o[n] = '{kind: KIND_EOF, data_byte: 8'd0, last: 1'b0};
        n        = n + 2'd1;
      end
      res_o[n - 2'd1].last = 1'b1;
      st = '0;
    end

    state_o = st;
    count_o = n;
  end

endmodule

// ===== design/cfs_checker.sv =====
// Port-level assertions for the CSV field splitter, bound to the top level.
module cfs_prop_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input cfs_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input cfs_pkg::out_item_t out_item_o
);
  import cfs_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // with nothing buffered the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while result buffer empty");

  // a non-quote byte or a line end always produces a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_item_i.text_byte != QUOTE_BYTE || in_item_i.line_end) |=> out_valid_o)
    else $error("request produced no result");

  // end-of-field marks carry a zero data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_EOF |-> out_item_o.data_byte == 8'd0)
    else $error("end-of-field mark with nonzero data");

endmodule

bind csv_field_splitter_top cfs_prop_checker u_cfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== sim/cfs_checker.sv =====
// Checker for the CSV field splitter: tracks quote state, predicts results, compares.
`timescale 1ns / 1ps

module cfs_checker
  import cfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        mismatches_o,
  output int        outstanding_o
);

  logic [7:0] delim;
  logic       in_quotes;
  logic       quote_pend;
  out_item_t  field_q [$];
  int         mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Works out the results one text byte causes and queues them in order.
  task automatic split_byte(input in_item_t it);
    out_item_t res [3];
    int        n;
    logic      consumed;
    logic      split;
    n = 0;
    consumed = 1'b0;
    split = 1'b0;
    if (quote_pend) begin
      quote_pend = 1'b0;
      if (it.text_byte == QUOTE_BYTE) begin
        // doubled quote inside a quoted section: one literal quote
        res[n] = '{kind: KIND_DATA, data_byte: QUOTE_BYTE, last: 1'b0};
        n++;
        consumed = 1'b1;
      end else begin
        in_quotes = 1'b0;
      end
    end
    if (!consumed) begin
      if (!in_quotes && it.text_byte == delim) begin
        res[n] = '{kind: KIND_EOF, data_byte: 8'h00, last: 1'b0};
        n++;
        split = 1'b1;
      end else if (it.text_byte == QUOTE_BYTE) begin
        if (!in_quotes) in_quotes = 1'b1;
        else quote_pend = 1'b1;
      end else begin
        res[n] = '{kind: KIND_DATA, data_byte: it.text_byte, last: 1'b0};
        n++;
      end
    end
    if (it.line_end) begin
      if (!split) begin
        res[n] = '{kind: KIND_EOF, data_byte: 8'h00, last: 1'b0};
        n++;
      end
      // trailing delimiter adds an empty field, quoted or not
      if (it.text_byte == delim) begin
        res[n] = '{kind: KIND_EOF, data_byte: 8'h00, last: 1'b0};
        n++;
      end
      res[n-1].last = 1'b1;
      in_quotes = 1'b0;
      quote_pend = 1'b0;
    end
    for (int i = 0; i < n; i++) field_q.insert(field_q.size(), res[i]);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (field_q.size() == 0) begin
      report_mismatch("result with nothing expected", int'(got), 0);
    end else begin
      want = field_q.pop_front();
      if (got.kind !== want.kind) report_mismatch("kind", int'(got.kind), int'(want.kind));
      if (got.data_byte !== want.data_byte)
        report_mismatch("data_byte", int'(got.data_byte), int'(want.data_byte));
      if (got.last !== want.last) report_mismatch("last", int'(got.last), int'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim = DELIM_RESET;
      in_quotes = 1'b0;
      quote_pend = 1'b0;
      field_q.delete();
      outstanding_o <= 0;
    end else begin
      // a result leaving now was caused by an earlier request
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (cfg_we_i) delim = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) split_byte(in_item_i);
      outstanding_o <= field_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the CSV field splitter: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import cfs_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int mismatches;
  int outstanding;

  logic [7:0] delim = DELIM_RESET;
  logic [7:0] line_q [$];
  logic [7:0] delim_plan [6];
  int         items_sent = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       hold_tgl = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  int         stop_at;

  csv_field_splitter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  cfs_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Receiver: random stalls, plus a long hold-off each time hold_tgl flips.
  always @(posedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("csv_field_splitter_top regression: fail");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic le);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= '{text_byte: b, line_end: le};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) push_byte(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic append_byte(input logic [7:0] b);
    line_q.insert(line_q.size(), b);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      if ($urandom_range(3) == 0) b = 8'($urandom_range(1, 255));
      else b = 8'($urandom_range(8'h61, 8'h7a));
    end while (b == QUOTE_BYTE || b == delim);
    return b;
  endfunction

  // Mostly well-formed fields (plain or quoted, with embedded delimiters and
  // doubled quotes); the rest is noise biased toward quotes and delimiters.
  task automatic make_line();
    int nf;
    int nb;
    line_q.delete();
    if ($urandom_range(99) < 80) begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) append_byte(delim);
        nb = $urandom_range(0, 4);
        if ($urandom_range(2) == 0) begin
          append_byte(QUOTE_BYTE);
          for (int k = 0; k < nb; k++) begin
            case ($urandom_range(5))
              0: append_byte(delim);
              1: begin
                append_byte(QUOTE_BYTE);
                append_byte(QUOTE_BYTE);
              end
              default: append_byte(plain_byte());
            endcase
          end
          // now and then leave the section unterminated
          if ($urandom_range(9) != 0) append_byte(QUOTE_BYTE);
        end else begin
          for (int k = 0; k < nb; k++) append_byte(plain_byte());
        end
      end
      if ($urandom_range(4) == 0) append_byte(delim);
    end else begin
      nb = $urandom_range(1, 8);
      for (int k = 0; k < nb; k++) begin
        case ($urandom_range(3))
          0: append_byte(QUOTE_BYTE);
          1: append_byte(delim);
          2: append_byte(plain_byte());
          default: append_byte(8'($urandom_range(1, 255)));
        endcase
      end
    end
    if (line_q.size() == 0) append_byte(plain_byte());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    // a quote byte yields nothing, so keep waiting after the queue empties
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_delim(input logic [7:0] d);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    delim = d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    delim_plan[0] = 8'd44;
    delim_plan[1] = 8'd255;
    delim_plan[2] = 8'd1;
    delim_plan[3] = QUOTE_BYTE;
    delim_plan[4] = 8'($urandom_range(1, 255));
    delim_plan[5] = 8'd44;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines at the reset delimiter
    send_text("\001,\377");
    send_text("\"a,\"\"q\",");
    send_text("\"z,");
    send_text("\"k\"");
    send_text("\"b\"\"");
    send_text(",");
    send_text("x\"y");

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct <= 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct <= 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      set_delim(delim_plan[ph]);
      // long receiver hold-off while requests keep coming
      if (ph == 5) hold_tgl <= ~hold_tgl;
      stop_at = items_sent + ITEMS_PER_PHASE;
      while (items_sent < stop_at) begin
        make_line();
        send_line();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("csv_field_splitter_top regression: pass");
    end else begin
      $display("csv_field_splitter_top regression: fail");
    end
    $finish;
  end

endmodule
